// ===== rtl/haversine_distance_top_assert.svh =====
// Assertion macros for the haversine distance pipeline
`ifndef HAVERSINE_DISTANCE_TOP_ASSERT_SVH
`define HAVERSINE_DISTANCE_TOP_ASSERT_SVH

// Implication checked on every edge outside reset
`define HD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define HD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/hav_pkg.sv =====
// Package: widths, constants and tables of the haversine distance pipeline
package hav_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int NSTG = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  localparam logic signed [63:0] PI_Q30       = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30  = 64'sd1686629713;
  localparam logic signed [63:0] ONE_Q30      = 64'sd1073741824;
  localparam logic signed [63:0] GAIN_INV_Q30 = 64'sd652032874;
  localparam logic [15:0]        RADIUS_RESET = 16'd6371;

  typedef logic signed [63:0] q_t;

  // one angle element travelling through a rotation CORDIC
  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic flip;
  } rot_t;

  function automatic q_t atan_q30(input int i);
    q_t t;
    case (i)
      0: t = 64'sh3243F6A8;  1: t = 64'sh1DAC6705;  2: t = 64'sh0FADBAFC;
      3: t = 64'sh07F56EA6;  4: t = 64'sh03FEAB76;  5: t = 64'sh01FFD55B;
      6: t = 64'sh00FFFAAA;  7: t = 64'sh007FFF55;  8: t = 64'sh003FFFEA;
      9: t = 64'sh001FFFFD; 10: t = 64'sh000FFFFF; 11: t = 64'sh0007FFFF;
      12: t = 64'sh0003FFFF; 13: t = 64'sh0001FFFF; 14: t = 64'sh0000FFFF;
      15: t = 64'sh00007FFF; 16: t = 64'sh00003FFF; 17: t = 64'sh00001FFF;
      18: t = 64'sh00000FFF; 19: t = 64'sh000007FF; 20: t = 64'sh000003FF;
      21: t = 64'sh000001FF; 22: t = 64'sh000000FF; 23: t = 64'sh0000007F;
      24: t = 64'sh0000003F; 25: t = 64'sh0000001F; 26: t = 64'sh0000000F;
      27: t = 64'sh00000008; 28: t = 64'sh00000004; 29: t = 64'sh00000002;
      30: t = 64'sh00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

  // q30 product of two 32-bit operands rounded, shift is arithmetic (floor)
  function automatic q_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
    q_t p;
    p = q_t'(a) * q_t'(b) + 64'sd536870912;
    return p >>> 30;
  endfunction

endpackage

// ===== rtl/hav_reduce.sv =====
// Angle reduction: fold degrees into a quadrant and scale to Q30 radians
module hav_reduce (
  input  logic           clk,
  input  logic           en,
  input  logic signed [31:0] deg,
  input  logic           frac23,
  output hav_pkg::rot_t  rot
);
  import hav_pkg::*;

  // ceil(2^43 / 45): exact floor division by 45 for dividends below 2^37
  localparam logic [37:0] RECIP45 = 38'd195468733827;
  localparam logic [18:0] RCP_HI  = RECIP45[37:19];
  localparam logic [18:0] RCP_LO  = RECIP45[18:0];

  logic signed [40:0] full, half, quarter, r0, r1, r2;
  logic               flip;
  logic [40:0]        mag;
  logic [62:0]        num;
  logic [62:0]        num_rnd;
  logic [36:0]        quo_in;
  logic [74:0]        prod;
  logic [31:0]        quo;
  logic [29:0]        mag_r;
  logic               neg_r, fr_r, flip_r;
  logic [36:0]        quo_in_r;
  logic               neg2_r, flip2_r;
  logic [36:0]        pp_hh_r, pp_hl_r;
  logic [37:0]        pp_lh_r, pp_ll_r;
  logic               neg3_r, flip3_r;
  q_t                 z;

  // stage A: wrap into [-180,180) and fold into [-90,90]
  always_comb begin
    full    = frac23 ? (41'sd360 <<< 23) : (41'sd360 <<< 22);
    half    = frac23 ? (41'sd180 <<< 23) : (41'sd180 <<< 22);
    quarter = frac23 ? (41'sd90 <<< 23)  : (41'sd90 <<< 22);
    r0 = 41'(deg);
    // |deg| < full, so one correction each way suffices
    if (r0 >= full) r1 = r0 - full;
    else if (r0 < 0) r1 = (r0 + full < 0) ? r0 + full + full : r0 + full;
    else r1 = r0;
    if (r1 >= half) r1 = r1 - full;
    flip = 1'b0;
    r2 = r1;
    if (r1 > quarter) begin
      r2 = r1 - half;
      flip = 1'b1;
    end else if (r1 < -quarter) begin
      r2 = r1 + half;
      flip = 1'b1;
    end
    mag = r2[40] ? 41'(-r2) : 41'(r2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag[29:0];
      neg_r  <= r2[40];
      fr_r   <= frac23;
      flip_r <= flip;
    end
  end

  // stage B: scale by pi, add half the divisor, drop the 2^(f+2) factor of 180 * 2^f
  always_comb begin
    num = 63'(mag_r) * 63'(PI_Q30[31:0]);
    if (fr_r) begin
      num_rnd = num + (63'd90 << 23);
      quo_in  = num_rnd[61:25];
    end else begin
      num_rnd = num + (63'd90 << 22);
      quo_in  = num_rnd[60:24];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_in_r <= quo_in;
      neg2_r   <= neg_r;
      flip2_r  <= flip_r;
    end
  end

  // stage C: partial products of the reciprocal multiplication by 1/45
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= 37'(quo_in_r[36:19]) * 37'(RCP_HI);
      pp_hl_r <= 37'(quo_in_r[36:19]) * 37'(RCP_LO);
      pp_lh_r <= 38'(quo_in_r[18:0]) * 38'(RCP_HI);
      pp_ll_r <= 38'(quo_in_r[18:0]) * 38'(RCP_LO);
      neg3_r  <= neg2_r;
      flip3_r <= flip2_r;
    end
  end

  // stage D: sum the partial products and restore the sign
  always_comb begin
    prod = (75'(pp_hh_r) << 38) + ((75'(pp_hl_r) + 75'(pp_lh_r)) << 19) + 75'(pp_ll_r);
    quo  = prod[74:43];
    z    = neg3_r ? -q_t'(quo) : q_t'(quo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot.x    <= GAIN_INV_Q30;
      rot.y    <= '0;
      rot.z    <= z;
      rot.flip <= flip3_r;
    end
  end

endmodule

// ===== rtl/hav_rot.sv =====
// Rotation-mode CORDIC, one register stage per iteration
module hav_rot (
  input  logic          clk,
  input  logic          en,
  input  hav_pkg::rot_t din,
  output hav_pkg::q_t   sin_o,
  output hav_pkg::q_t   cos_o
);
  import hav_pkg::*;

  rot_t stg_r [NSTG+1];

  always_comb stg_r[0] = din;

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    rot_t nxt;
    always_comb begin
      nxt = stg_r[i];
      if (stg_r[i].z >= 0) begin
        nxt.x = stg_r[i].x - (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y + (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z - atan_q30(i);
      end else begin
        nxt.x = stg_r[i].x + (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y - (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z + atan_q30(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) stg_r[i+1] <= nxt;
    end
  end

  assign sin_o = stg_r[NSTG].flip ? -stg_r[NSTG].y : stg_r[NSTG].y;
  assign cos_o = stg_r[NSTG].flip ? -stg_r[NSTG].x : stg_r[NSTG].x;

endmodule

// ===== rtl/hav_sqrt.sv =====
// Pipelined bitwise square root of a Q30 value, one result bit per stage
module hav_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] v,
  output logic [31:0] root
);
  localparam int NS = 32;

  logic [63:0] n_r [NS+1];
  logic [63:0] r_r [NS+1];

  always_comb begin
    n_r[0] = {v, 30'd0} & 64'h3FFF_FFFF_FFFF_FFFF;
    r_r[0] = '0;
  end

  // bit walks 2^62 down to 2^0; leading zero stages keep r at zero
  for (genvar i = 0; i < NS; i++) begin : g_stg
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] n_nxt, r_nxt;
    always_comb begin
      if (n_r[i] >= r_r[i] + BIT) begin
        n_nxt = n_r[i] - (r_r[i] + BIT);
        r_nxt = (r_r[i] >> 1) + BIT;
      end else begin
        n_nxt = n_r[i];
        r_nxt = r_r[i] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_nxt;
        r_r[i+1] <= r_nxt;
      end
    end
  end

  assign root = r_r[NS][31:0];

endmodule

// ===== rtl/haversine_distance_top.sv =====
// Top level: haversine great-circle distance pipeline
//
// channel  direction  handshake         payload
// in       input      in_valid/in_stall lon_a, lat_a, lon_b, lat_b
// out      output     out_valid/out_stall distance_km
// cfg      input      cfg_valid/cfg_ready earth_radius_km
//
// One item enters per clock while in_stall is low; the pipeline is made of
// the two chained CORDIC pipelines and the 32-stage square roots, plus
// four reduction, three product and two scaling stages.
// The whole pipe advances as one shift chain: it holds when the output
// register is full and stalled, so bubbles do not compress under stall.
// Reset (rst_n low, synchronous) clears all valid bits and loads radius 6371.
module haversine_distance_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [30:0] in_lon_a,
  input  logic signed [29:0] in_lat_a,
  input  logic signed [30:0] in_lon_b,
  input  logic signed [29:0] in_lat_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_distance_km,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_earth_radius_km
);
  import hav_pkg::*;
  `include "haversine_distance_top_assert.svh"

  // stage counts: reduce 4, rotate NSTG, products 3, roots 32, atan NSTG+1, scale 2
  localparam int LAT = 4 + NSTG + 3 + 32 + NSTG + 1 + 2;

  logic [15:0] radius_r;
  logic        en;
  logic        vld_r [LAT];

  // advance whenever the output slot is empty or being taken
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RADIUS_RESET;
    else if (cfg_valid) radius_r <= cfg_earth_radius_km;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end
  assign out_valid = vld_r[LAT-1];

  // four sine/cosine engines in parallel
  rot_t rin [4];
  q_t   sn [4];
  q_t   cs [4];

  hav_reduce u_red0 (.clk, .en, .deg(32'(in_lat_a) - 32'(in_lat_b)), .frac23(1'b1),
                     .rot(rin[0]));
  hav_reduce u_red1 (.clk, .en, .deg(32'(in_lon_a) - 32'(in_lon_b)), .frac23(1'b1),
                     .rot(rin[1]));
  hav_reduce u_red2 (.clk, .en, .deg(32'(in_lat_a)), .frac23(1'b0), .rot(rin[2]));
  hav_reduce u_red3 (.clk, .en, .deg(32'(in_lat_b)), .frac23(1'b0), .rot(rin[3]));

  for (genvar k = 0; k < 4; k++) begin : g_rot
    hav_rot u_rot (.clk, .en, .din(rin[k]), .sin_o(sn[k]), .cos_o(cs[k]));
  end

  // products, one multiply level per stage; sines, cosines and products fit 32 bits
  q_t p_dlat_r, p_cc_r, p_dlon_r, p_t_r;
  q_t a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_dlat_r <= mulq(sn[0][31:0], sn[0][31:0]);
      p_cc_r   <= mulq(cs[2][31:0], cs[3][31:0]);
      p_dlon_r <= mulq(sn[1][31:0], sn[1][31:0]);
    end
  end
  q_t p_dlat2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_t_r     <= mulq(p_cc_r[31:0], p_dlon_r[31:0]);
      p_dlat2_r <= p_dlat_r;
    end
  end
  q_t a_sum;
  always_comb begin
    a_sum = p_dlat2_r + p_t_r;
    if (a_sum < 0) a_sum = '0;
    if (a_sum > ONE_Q30) a_sum = ONE_Q30;
  end
  always_ff @(posedge clk) begin
    if (en) a_r <= a_sum;
  end

  logic [31:0] rt_a, rt_b;
  hav_sqrt u_sq_a (.clk, .en, .v(a_r[31:0]), .root(rt_a));
  hav_sqrt u_sq_b (.clk, .en, .v(32'(ONE_Q30 - a_r)), .root(rt_b));

  // vectoring CORDIC for the central half-angle
  q_t vx_r [NSTG+1];
  q_t vy_r [NSTG+1];
  q_t vz_r [NSTG+1];
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= q_t'(rt_b);
      vy_r[0] <= q_t'(rt_a);
      vz_r[0] <= '0;
    end
  end
  for (genvar i = 0; i < NSTG; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + atan_q30(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - atan_q30(i);
        end
      end
    end
  end

  // clamp angle, scale by radius, round and saturate
  logic [31:0] ang_r;
  q_t          zc;
  always_comb begin
    zc = vz_r[NSTG];
    if (zc < 0) zc = '0;
    if (zc > HALF_PI_Q30) zc = HALF_PI_Q30;
  end
  logic [15:0] rad_q;
  assign rad_q = radius_r;
  logic [49:0] prod_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= zc[31:0];
      prod_r <= 50'(rad_q) * 50'(zc[31:0]);
    end
  end
  logic [50:0] scaled;
  always_comb scaled = ({prod_r, 1'b0} + 51'd8192) >> 14;
  always_ff @(posedge clk) begin
    if (en) out_distance_km <= (scaled > 51'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
  end

  `HD_ASSERT_IMP(a_hold_out, clk, rst_n, out_valid && out_stall, in_stall)
  `HD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_distance_km))
  `HD_ASSERT_IMP(a_angle_q, clk, rst_n, vld_r[LAT-2], ang_r <= HALF_PI_Q30[31:0])

endmodule
